// ===== rtl/bcjx_pkg.sv =====
`default_nettype none
package bcjx_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned WIN_LEN = 5;

    localparam logic [2:0] C_WIN_LAST = 3'd4;
    localparam logic [BYTE_W-1:0] C_OPC_MASK = 8'hFE;
    localparam logic [BYTE_W-1:0] C_OPC_CALL = 8'hE8;
    localparam logic [BYTE_W-1:0] C_MS_ONES = 8'hFF;
    localparam logic [BYTE_W-1:0] C_MS_ZERO = 8'h00;
    localparam logic [2:0] C_MASK3 = 3'h7;
    localparam logic [WORD_W-1:0] C_IP_OFFSET = 32'd5;
    localparam logic [WORD_W-1:0] C_LPOS_RESET = 32'hFFFF_FFFF;
    localparam logic [1:0] C_LAST_PASS = 2'd2;
    localparam logic [2:0] C_LEAVE_ONE = 3'd1;
    localparam logic [2:0] C_LEAVE_ALL = 3'd5;

    typedef struct packed {
        logic              sub;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_alu_req;

    function automatic logic is_ms(input logic [BYTE_W-1:0] b);
        return (b == C_MS_ZERO) || (b == C_MS_ONES);
    endfunction

    function automatic logic allowed(input logic [2:0] m);
        logic r;
        case (m)
            3'd0, 3'd1, 3'd2, 3'd4: r = 1'b1;
            default:                r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] bitnum(input logic [2:0] m);
        logic [1:0] r;
        case (m)
            3'd0:       r = 2'd0;
            3'd1:       r = 2'd1;
            3'd2, 3'd3: r = 2'd2;
            default:    r = 2'd3;
        endcase
        return r;
    endfunction

    // low-bit mask flipped between passes, indexed by bitnum
    function automatic logic [WORD_W-1:0] flip_mask(input logic [1:0] bn);
        logic [WORD_W-1:0] r;
        case (bn)
            2'd1:    r = 32'h00FF_FFFF;
            2'd2:    r = 32'h0000_FFFF;
            default: r = 32'h0000_00FF;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bcjx_if.sv =====
`default_nettype none
interface bcjx_in_if;
    import bcjx_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface bcjx_out_if;
    import bcjx_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

interface bcjx_cfg_if;
    logic valid;
    logic ready;
    logic encode_mode;
    modport source (output valid, output encode_mode, input ready);
    modport sink (input valid, input encode_mode, output ready);
endinterface
`default_nettype wire

// ===== rtl/bcjx_alu.sv =====
`default_nettype none
module bcjx_alu (
    input  var bcjx_pkg::t_alu_req          i_req,
    output logic [bcjx_pkg::WORD_W-1:0]     o_sum
);
    import bcjx_pkg::*;

    logic [WORD_W-1:0] w_b;

    assign w_b   = i_req.sub ? ~i_req.b : i_req.b;
    assign o_sum = i_req.a + w_b + {{(WORD_W-1){1'b0}}, i_req.sub};

endmodule
`default_nettype wire

// ===== rtl/x86_branch_address_filter.sv =====
// Flow: bytes are taken only in idle until the window fills; a full window is examined for an E8/E9 opcode.
// No opcode, or a vetoed or unconverted one: the first window byte is emitted and the window slides.
// Rewrite: one to three add/subtract passes, then all five window bytes are emitted; flush drains the rest.
// All arithmetic shares the single 32-bit adder; output goes through a one-byte output register.
// Reset (synchronous, active low) clears the stream state and sets encode mode.
`default_nettype none
module x86_branch_address_filter (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bcjx_in_if.sink    i_in,
    bcjx_out_if.source o_out,
    bcjx_cfg_if.sink   i_cfg
);
    import bcjx_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXAM = 3'd1;
    localparam logic [2:0] S_MASK = 3'd2;
    localparam logic [2:0] S_PASS = 3'd3;
    localparam logic [2:0] S_PCHK = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [BYTE_W-1:0] r_win [WIN_LEN];
    logic [BYTE_W-1:0] n_win [WIN_LEN];
    logic [2:0]        r_fill, n_fill;
    logic [WORD_W-1:0] r_pos, n_pos;
    logic [WORD_W-1:0] r_lpos, n_lpos;
    logic [2:0]        r_rmask, n_rmask;
    logic              r_mode;
    logic              r_ovalid, n_ovalid;
    logic [BYTE_W-1:0] r_obyte, n_obyte;
    logic              r_olast, n_olast;
    logic              r_last, n_last;
    logic [2:0]        r_cnt, n_cnt;
    logic [2:0]        r_mask, n_mask;
    logic [1:0]        r_pass, n_pass;
    logic [WORD_W-1:0] r_acc, n_acc;
    logic [WORD_W-1:0] r_k, n_k;
    logic [WORD_W-1:0] r_src, n_src;

    t_alu_req          w_req;
    logic [WORD_W-1:0] w_sum;
    logic              w_in_xfer;
    logic              w_near;
    logic [2:0]        w_mshift;
    logic [2:0]        w_m;
    logic [2:0]        w_vidx;
    logic              w_veto;
    logic [1:0]        w_pbn;
    logic [BYTE_W-1:0] w_pbyte;
    logic              w_done;

    bcjx_alu u_alu (
        .i_req (w_req),
        .o_sum (w_sum)
    );

    assign i_in.ready     = (r_state == S_IDLE);
    assign w_in_xfer      = i_in.valid && i_in.ready;
    assign i_cfg.ready    = 1'b1;
    assign o_out.valid    = r_ovalid;
    assign o_out.out_byte = r_obyte;
    assign o_out.out_last = r_olast;

    // recent-mask alignment to distance since last opcode
    always_comb begin
        w_near = (r_acc[WORD_W-1:2] == '0) && (r_acc[1:0] != 2'd0);
        case (r_acc[1:0])
            2'd1:    w_mshift = r_rmask;
            2'd2:    w_mshift = {r_rmask[1:0], 1'b0};
            2'd3:    w_mshift = {r_rmask[0], 2'b00};
            default: w_mshift = 3'd0;
        endcase
        w_m    = w_near ? (w_mshift & C_MASK3) : 3'd0;
        w_vidx = C_WIN_LAST - {1'b0, bitnum(w_m)};
        w_veto = (w_m != 3'd0) && (!allowed(w_m) || is_ms(r_win[w_vidx]));
        w_pbn  = bitnum(r_mask);
        case (w_pbn)
            2'd1:    w_pbyte = r_acc[23:16];
            2'd2:    w_pbyte = r_acc[15:8];
            default: w_pbyte = r_acc[7:0];
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_win    = r_win;
        n_fill   = r_fill;
        n_pos    = r_pos;
        n_lpos   = r_lpos;
        n_rmask  = r_rmask;
        n_ovalid = r_ovalid;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        n_last   = r_last;
        n_cnt    = r_cnt;
        n_mask   = r_mask;
        n_pass   = r_pass;
        n_acc    = r_acc;
        n_k      = r_k;
        n_src    = r_src;
        w_done   = 1'b0;
        w_req    = '{sub: 1'b0, a: r_pos, b: 32'd1};

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_win[r_fill] = i_in.in_byte;
                    n_fill        = r_fill + 3'd1;
                    n_last        = i_in.in_last;
                    if (r_fill == C_WIN_LAST) begin
                        n_state = S_EXAM;
                    end else if (i_in.in_last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EXAM: begin
                w_req = '{sub: 1'b1, a: r_pos, b: r_lpos};
                if ((r_win[0] & C_OPC_MASK) != C_OPC_CALL) begin
                    n_cnt   = C_LEAVE_ONE;
                    n_state = S_EMIT;
                end else begin
                    n_acc   = w_sum;
                    n_state = S_MASK;
                end
            end
            S_MASK: begin
                w_req  = '{sub: 1'b0, a: r_pos, b: C_IP_OFFSET};
                n_lpos = r_pos;
                if (w_veto || !is_ms(r_win[4])) begin
                    n_rmask = {w_m[1:0], 1'b1};
                    n_cnt   = C_LEAVE_ONE;
                    n_state = S_EMIT;
                end else begin
                    n_mask  = w_m;
                    n_k     = w_sum;
                    n_src   = {r_win[4], r_win[3], r_win[2], r_win[1]};
                    n_pass  = 2'd0;
                    n_state = S_PASS;
                end
            end
            S_PASS: begin
                if (r_mode) begin
                    w_req = '{sub: 1'b0, a: r_k, b: r_src};
                end else begin
                    w_req = '{sub: 1'b1, a: r_src, b: r_k};
                end
                n_acc   = w_sum;
                n_state = S_PCHK;
            end
            S_PCHK: begin
                if ((r_mask == 3'd0) || !is_ms(w_pbyte) || (r_pass == C_LAST_PASS)) begin
                    n_win[4] = r_acc[24] ? C_MS_ONES : C_MS_ZERO;
                    n_win[3] = r_acc[23:16];
                    n_win[2] = r_acc[15:8];
                    n_win[1] = r_acc[7:0];
                    n_rmask  = r_mask;
                    n_cnt    = C_LEAVE_ALL;
                    n_state  = S_EMIT;
                end else begin
                    n_src   = r_acc ^ flip_mask(w_pbn);
                    n_pass  = r_pass + 2'd1;
                    n_state = S_PASS;
                end
            end
            S_EMIT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_obyte  = r_win[0];
                    n_olast  = r_last && (r_fill == 3'd1);
                    for (int i = 0; i < WIN_LEN - 1; i++) begin
                        n_win[i] = r_win[i+1];
                    end
                    n_win[WIN_LEN-1] = '0;
                    n_fill = r_fill - 3'd1;
                    n_pos  = w_sum;
                    n_cnt  = r_cnt - 3'd1;
                    w_done = r_last ? (r_fill == 3'd1) : (r_cnt == 3'd1);
                    if (w_done) begin
                        n_state = S_IDLE;
                        if (r_last) begin
                            for (int i = 0; i < WIN_LEN; i++) begin
                                n_win[i] = '0;
                            end
                            n_fill  = 3'd0;
                            n_pos   = '0;
                            n_rmask = 3'd0;
                            n_lpos  = C_LPOS_RESET;
                            n_last  = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= 3'd0;
            r_pos    <= '0;
            r_lpos   <= C_LPOS_RESET;
            r_rmask  <= 3'd0;
            r_ovalid <= 1'b0;
            r_last   <= 1'b0;
            r_mode   <= 1'b1;
            for (int i = 0; i < WIN_LEN; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_pos    <= n_pos;
            r_lpos   <= n_lpos;
            r_rmask  <= n_rmask;
            r_ovalid <= n_ovalid;
            r_last   <= n_last;
            r_win    <= n_win;
            if (i_cfg.valid && i_cfg.ready) begin
                r_mode <= i_cfg.encode_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        r_cnt   <= n_cnt;
        r_mask  <= n_mask;
        r_pass  <= n_pass;
        r_acc   <= n_acc;
        r_k     <= n_k;
        r_src   <= n_src;
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= C_LEAVE_ALL)
        else $error("window fill out of range");

    a_idle_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_fill < C_LEAVE_ALL))
        else $error("idle with a full window");

    a_exam_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXAM) || (r_state == S_MASK)) |-> (r_fill == C_LEAVE_ALL))
        else $error("examine without a full window");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_fill != 3'd0))
        else $error("emit from empty window");

    a_pass_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PCHK) |-> (r_pass <= C_LAST_PASS))
        else $error("too many conversion passes");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_last && r_fill == 3'd1 && (!r_ovalid || o_out.ready))
        |=> (r_fill == 3'd0 && r_pos == '0 && r_lpos == C_LPOS_RESET))
        else $error("stream state not cleared after flush");

endmodule
`default_nettype wire
